### rtl/wti_pkg.sv
package wti_pkg;

    localparam int TABLE_DEPTH_DEF = 64;
    localparam int TIME_WIDTH_DEF  = 48;

    typedef enum logic [1:0] {
        ACT_SET = 2'd0,
        ACT_DEL = 2'd1,
        ACT_CLR = 2'd2,
        ACT_QRY = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BEFORE = 2'd1,
        ST_AFTER  = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    // read address sources
    typedef enum logic [2:0] {
        RSEL_IDX = 3'd0,
        RSEL_KM1 = 3'd1,
        RSEL_KP1 = 3'd2,
        RSEL_PV  = 3'd3,
        RSEL_NX  = 3'd4
    } t_rsel;

    typedef struct packed {
        logic    load_in;
        logic    idx_inc;
        logic    pos_set;
        logic    pos_eq;
        t_rsel   rd_sel;
        logic    wr_en;
        logic    wd_new;
        logic    wa_pos;
        logic    k_load_cnt;
        logic    k_load_pos;
        logic    k_dec;
        logic    k_inc;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    cnt_clr;
        logic    cap_a;
        logic    cap_b;
        logic    md_start;
        logic    st_load;
        t_status st_val;
        logic    out_load;
    } t_cmd;

    typedef struct packed {
        t_action act;
        logic    scan_end;
        logic    rd_less;
        logic    rd_eq;
        logic    found;
        logic    full;
        logic    shift_more;
        logic    del_more;
        logic    nx_past;
        logic    nx_zero;
        logic    md_done;
        logic    out_free;
    } t_stat;

endpackage

### rtl/wti_ram.sv
module wti_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/wti_muldiv.sv
module wti_muldiv #(
    parameter int TIME_WIDTH = wti_pkg::TIME_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [31:0]           i_mag,
    input  logic [TIME_WIDTH-1:0] i_dt,
    input  logic [TIME_WIDTH-1:0] i_span,
    output logic [31:0]           o_quo,
    output logic                  o_done
);

    localparam int PW = TIME_WIDTH + 32;

    logic                  r_busy;
    logic                  r_div;
    logic                  r_done;
    logic [4:0]            r_cnt;
    logic [31:0]           r_m;
    logic [PW-1:0]         r_dsh;
    logic [PW-1:0]         r_acc;
    logic [TIME_WIDTH-1:0] r_span;

    logic [TIME_WIDTH:0]   trial;
    logic                  ge;
    logic [TIME_WIDTH:0]   diff;

    // restoring division step: remainder in the upper part, quotient shifts in below
    assign trial = {r_acc[PW-1:32], r_acc[31]};
    assign ge    = trial >= {1'b0, r_span};
    assign diff  = trial - {1'b0, r_span};

    // control: 32 shift-add steps, then 32 divide steps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_div  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_div  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 5'd1;
            if (r_cnt == 5'd31) begin
                if (r_div) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_div <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_m    <= i_mag;
            r_dsh  <= PW'(i_dt);
            r_acc  <= '0;
            r_span <= i_span;
        end else if (r_busy) begin
            if (!r_div) begin
                if (r_m[0]) begin
                    r_acc <= r_acc + r_dsh;
                end
                r_dsh <= {r_dsh[PW-2:0], 1'b0};
                r_m   <= {1'b0, r_m[31:1]};
            end else begin
                r_acc <= {(ge ? diff[TIME_WIDTH-1:0] : trial[TIME_WIDTH-1:0]),
                          r_acc[30:0], ge};
            end
        end
    end

    assign o_quo  = r_acc[31:0];
    assign o_done = r_done;

endmodule

### rtl/wti_datapath.sv
module wti_datapath #(
    parameter int TABLE_DEPTH = wti_pkg::TABLE_DEPTH_DEF,
    parameter int TIME_WIDTH  = wti_pkg::TIME_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  wti_pkg::t_cmd i_cmd,
    output wti_pkg::t_stat o_stat,
    input  logic [1:0]    i_action,
    input  logic [47:0]   i_time_stamp,
    input  logic [31:0]   i_latitude,
    input  logic [31:0]   i_longitude,
    input  logic [31:0]   i_altitude,
    input  logic          i_out_stall,
    output logic          o_out_valid,
    output logic [1:0]    o_status,
    output logic [31:0]   o_point_latitude,
    output logic [31:0]   o_point_longitude,
    output logic [31:0]   o_point_altitude,
    output logic [6:0]    o_entry_count
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int RW = TIME_WIDTH + 96;
    localparam logic [CW-1:0] FULL_CNT = CW'(TABLE_DEPTH);

    wti_pkg::t_action      r_act;
    wti_pkg::t_status      r_status;
    logic [TIME_WIDTH-1:0] r_t;
    logic [31:0]           r_lat, r_lon, r_alt;
    logic [CW-1:0]         r_cnt, r_idx, r_pos, r_k;
    logic                  r_eq;
    logic [RW-1:0]         r_a, r_b;
    logic                  r_out_valid;
    logic [1:0]            r_o_status;
    logic [31:0]           r_o_lat, r_o_lon, r_o_alt;
    logic [6:0]            r_o_cnt;

    logic [63:0]           ts_ext;
    logic [63:0]           cnt_ext;
    logic [CW-1:0]         nx;
    logic [CW-1:0]         rd_idx;
    logic [AW-1:0]         raddr, waddr;
    logic [RW-1:0]         wdata, rdata;
    logic [TIME_WIDTH-1:0] dt, span;
    logic [31:0]           a_c [3];
    logic [31:0]           b_c [3];
    logic [31:0]           quo [3];
    logic [31:0]           res [3];
    logic [2:0]            done;
    logic                  out_free;
    logic                  pt_ok;

    assign ts_ext  = 64'(i_time_stamp);
    assign nx      = r_pos + CW'(r_eq);
    assign out_free = !r_out_valid || !i_out_stall;

    // read address select
    always_comb begin
        case (i_cmd.rd_sel)
            wti_pkg::RSEL_IDX: rd_idx = r_idx;
            wti_pkg::RSEL_KM1: rd_idx = r_k - CW'(1);
            wti_pkg::RSEL_KP1: rd_idx = r_k + CW'(1);
            wti_pkg::RSEL_PV:  rd_idx = nx - CW'(1);
            wti_pkg::RSEL_NX:  rd_idx = nx;
            default:           rd_idx = r_idx;
        endcase
    end

    assign raddr = rd_idx[AW-1:0];
    assign waddr = i_cmd.wa_pos ? r_pos[AW-1:0] : r_k[AW-1:0];
    assign wdata = i_cmd.wd_new ? {r_t, r_lat, r_lon, r_alt} : rdata;

    wti_ram #(.WIDTH(RW), .DEPTH(TABLE_DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_en),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // status toward the controller
    always_comb begin
        o_stat.act        = r_act;
        o_stat.scan_end   = r_idx >= r_cnt;
        o_stat.rd_less    = rdata[RW-1:96] < r_t;
        o_stat.rd_eq      = rdata[RW-1:96] == r_t;
        o_stat.found      = r_eq;
        o_stat.full       = r_cnt == FULL_CNT;
        o_stat.shift_more = r_k > r_pos;
        o_stat.del_more   = ({1'b0, r_k} + (CW+1)'(1)) < {1'b0, r_cnt};
        o_stat.nx_past    = nx >= r_cnt;
        o_stat.nx_zero    = nx == '0;
        o_stat.md_done    = &done;
        o_stat.out_free   = out_free;
    end

    // interpolation: three coordinates in parallel
    assign dt   = r_t - r_a[RW-1:96];
    assign span = r_b[RW-1:96] - r_a[RW-1:96];
    assign a_c[0] = r_a[95:64];
    assign a_c[1] = r_a[63:32];
    assign a_c[2] = r_a[31:0];
    assign b_c[0] = r_b[95:64];
    assign b_c[1] = r_b[63:32];
    assign b_c[2] = r_b[31:0];

    for (genvar g = 0; g < 3; g++) begin : g_coord
        logic [32:0] diff;
        logic [32:0] mag;
        logic        neg;

        assign diff = {b_c[g][31], b_c[g]} - {a_c[g][31], a_c[g]};
        assign neg  = diff[32];
        assign mag  = neg ? (33'd0 - diff) : diff;

        wti_muldiv #(.TIME_WIDTH(TIME_WIDTH)) u_md (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start (i_cmd.md_start),
            .i_mag   (mag[31:0]),
            .i_dt    (dt),
            .i_span  (span),
            .o_quo   (quo[g]),
            .o_done  (done[g])
        );

        assign res[g] = neg ? (a_c[g] - quo[g]) : (a_c[g] + quo[g]);
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.cnt_clr) begin
                r_cnt <= '0;
            end else if (i_cmd.cnt_inc) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (i_cmd.cnt_dec) begin
                r_cnt <= r_cnt - CW'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item and working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_act    <= wti_pkg::t_action'(i_action);
            r_t      <= ts_ext[TIME_WIDTH-1:0];
            r_lat    <= i_latitude;
            r_lon    <= i_longitude;
            r_alt    <= i_altitude;
            r_idx    <= '0;
            r_status <= wti_pkg::ST_OK;
        end else begin
            if (i_cmd.idx_inc) begin
                r_idx <= r_idx + CW'(1);
            end
            if (i_cmd.st_load) begin
                r_status <= i_cmd.st_val;
            end
        end
        if (i_cmd.pos_set) begin
            r_pos <= r_idx;
            r_eq  <= i_cmd.pos_eq;
        end
        if (i_cmd.k_load_cnt) begin
            r_k <= r_cnt;
        end else if (i_cmd.k_load_pos) begin
            r_k <= r_pos;
        end else if (i_cmd.k_dec) begin
            r_k <= r_k - CW'(1);
        end else if (i_cmd.k_inc) begin
            r_k <= r_k + CW'(1);
        end
        if (i_cmd.cap_a) begin
            r_a <= rdata;
        end
        if (i_cmd.cap_b) begin
            r_b <= rdata;
        end
    end

    // result register
    assign pt_ok   = (r_act == wti_pkg::ACT_QRY) && (r_status == wti_pkg::ST_OK);
    assign cnt_ext = 64'(r_cnt);

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_status <= r_status;
            r_o_lat    <= pt_ok ? res[0] : 32'd0;
            r_o_lon    <= pt_ok ? res[1] : 32'd0;
            r_o_alt    <= pt_ok ? res[2] : 32'd0;
            r_o_cnt    <= cnt_ext[6:0];
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_o_status;
    assign o_point_latitude  = r_o_lat;
    assign o_point_longitude = r_o_lon;
    assign o_point_altitude  = r_o_alt;
    assign o_entry_count     = r_o_cnt;

endmodule

### rtl/wti_ctrl.sv
module wti_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  wti_pkg::t_stat i_stat,
    output wti_pkg::t_cmd  o_cmd
);

    typedef enum logic [12:0] {
        S_IDLE   = 13'b0000000000001,
        S_SRD    = 13'b0000000000010,
        S_SCMP   = 13'b0000000000100,
        S_DECIDE = 13'b0000000001000,
        S_SHRD   = 13'b0000000010000,
        S_SHWR   = 13'b0000000100000,
        S_WRNEW  = 13'b0000001000000,
        S_DLRD   = 13'b0000010000000,
        S_DLWR   = 13'b0000100000000,
        S_QRD1   = 13'b0001000000000,
        S_QCAP   = 13'b0010000000000,
        S_QSTART = 13'b0100000000000,
        S_QWAIT  = 13'b1000000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_done_pend, n_done_pend;

    // state register; r_done_pend marks the result-load wait
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_done_pend <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_done_pend <= n_done_pend;
        end
    end

    assign o_in_stall = (r_state != S_IDLE) || r_done_pend;

    // next state and commands
    always_comb begin
        n_state     = r_state;
        n_done_pend = r_done_pend;
        o_cmd       = '0;
        o_cmd.rd_sel = wti_pkg::RSEL_IDX;
        o_cmd.st_val = wti_pkg::ST_OK;
        case (r_state)
            S_IDLE: begin
                if (r_done_pend) begin
                    if (i_stat.out_free) begin
                        o_cmd.out_load = 1'b1;
                        n_done_pend    = 1'b0;
                    end
                end else if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_SRD;
                end
            end
            S_SRD: begin
                if (i_stat.scan_end) begin
                    o_cmd.pos_set = 1'b1;
                    n_state       = S_DECIDE;
                end else begin
                    n_state = S_SCMP;
                end
            end
            S_SCMP: begin
                if (i_stat.rd_less) begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_SRD;
                end else begin
                    o_cmd.pos_set = 1'b1;
                    o_cmd.pos_eq  = i_stat.rd_eq;
                    n_state       = S_DECIDE;
                end
            end
            S_DECIDE: begin
                case (i_stat.act)
                    wti_pkg::ACT_SET: begin
                        if (i_stat.found) begin
                            n_state = S_WRNEW;
                        end else if (i_stat.full) begin
                            o_cmd.st_load = 1'b1;
                            o_cmd.st_val  = wti_pkg::ST_FULL;
                            n_state       = S_IDLE;
                            n_done_pend   = 1'b1;
                        end else begin
                            o_cmd.k_load_cnt = 1'b1;
                            n_state          = S_SHRD;
                        end
                    end
                    wti_pkg::ACT_DEL: begin
                        if (i_stat.found) begin
                            o_cmd.k_load_pos = 1'b1;
                            n_state          = S_DLRD;
                        end else begin
                            n_state     = S_IDLE;
                            n_done_pend = 1'b1;
                        end
                    end
                    wti_pkg::ACT_CLR: begin
                        o_cmd.cnt_clr = 1'b1;
                        n_state       = S_IDLE;
                        n_done_pend   = 1'b1;
                    end
                    default: begin
                        if (i_stat.nx_past) begin
                            o_cmd.st_load = 1'b1;
                            o_cmd.st_val  = wti_pkg::ST_AFTER;
                            n_state       = S_IDLE;
                            n_done_pend   = 1'b1;
                        end else if (i_stat.nx_zero) begin
                            o_cmd.st_load = 1'b1;
                            o_cmd.st_val  = wti_pkg::ST_BEFORE;
                            n_state       = S_IDLE;
                            n_done_pend   = 1'b1;
                        end else begin
                            o_cmd.rd_sel = wti_pkg::RSEL_PV;
                            n_state      = S_QRD1;
                        end
                    end
                endcase
            end
            // open a gap for the new entry, top down
            S_SHRD: begin
                if (i_stat.shift_more) begin
                    o_cmd.rd_sel = wti_pkg::RSEL_KM1;
                    n_state      = S_SHWR;
                end else begin
                    n_state = S_WRNEW;
                end
            end
            S_SHWR: begin
                o_cmd.wr_en = 1'b1;
                o_cmd.k_dec = 1'b1;
                n_state     = S_SHRD;
            end
            S_WRNEW: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wd_new  = 1'b1;
                o_cmd.wa_pos  = 1'b1;
                o_cmd.cnt_inc = !i_stat.found;
                n_state       = S_IDLE;
                n_done_pend   = 1'b1;
            end
            // close the gap of a deleted entry, bottom up
            S_DLRD: begin
                if (i_stat.del_more) begin
                    o_cmd.rd_sel = wti_pkg::RSEL_KP1;
                    n_state      = S_DLWR;
                end else begin
                    o_cmd.cnt_dec = 1'b1;
                    n_state       = S_IDLE;
                    n_done_pend   = 1'b1;
                end
            end
            S_DLWR: begin
                o_cmd.wr_en = 1'b1;
                o_cmd.k_inc = 1'b1;
                n_state     = S_DLRD;
            end
            S_QRD1: begin
                o_cmd.cap_a  = 1'b1;
                o_cmd.rd_sel = wti_pkg::RSEL_NX;
                n_state      = S_QCAP;
            end
            S_QCAP: begin
                o_cmd.cap_b = 1'b1;
                n_state     = S_QSTART;
            end
            S_QSTART: begin
                o_cmd.md_start = 1'b1;
                n_state        = S_QWAIT;
            end
            S_QWAIT: begin
                if (i_stat.md_done) begin
                    n_state     = S_IDLE;
                    n_done_pend = 1'b1;
                end
            end
            default: begin
                n_state     = S_IDLE;
                n_done_pend = 1'b0;
            end
        endcase
    end

endmodule

### rtl/waypoint_table_interpolator.sv
// Waypoint table interpolator: a time-sorted table of up to TABLE_DEPTH
// waypoints with set, delete, clear and query actions.
// Input channel: i_in_valid / o_in_stall with i_action, i_time_stamp and the
// coordinates; a transfer happens when valid is high and stall is low.
// Output channel: o_out_valid / i_out_stall, one result per input transfer.
// Every action first scans the table from the start, a read and a compare state
// per entry below the insert position (RAM with a registered read port).
// Set then shifts the entries from the position up, each read then written;
// a set of an existing time overwrites that entry instead; delete shifts them
// down the same way; clear ends right after the scan. A query reads both
// neighbors and runs three shift-add multiply and restoring divide units in
// parallel. One item in flight.
// A finished result sits in the output register; the next item is taken
// while it waits, but that item's result waits in turn until it drains.
// Reset empties the table at once (count to zero), no clearing pass.

module waypoint_table_interpolator #(
    parameter int TABLE_DEPTH = wti_pkg::TABLE_DEPTH_DEF,
    parameter int TIME_WIDTH  = wti_pkg::TIME_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_action,
    input  logic [47:0] i_time_stamp,
    input  logic [31:0] i_latitude,
    input  logic [31:0] i_longitude,
    input  logic [31:0] i_altitude,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [31:0] o_point_latitude,
    output logic [31:0] o_point_longitude,
    output logic [31:0] o_point_altitude,
    output logic [6:0]  o_entry_count
);

    wti_pkg::t_cmd  cmd;
    wti_pkg::t_stat stat;

    wti_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    wti_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .TIME_WIDTH  (TIME_WIDTH)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_action          (i_action),
        .i_time_stamp      (i_time_stamp),
        .i_latitude        (i_latitude),
        .i_longitude       (i_longitude),
        .i_altitude        (i_altitude),
        .i_out_stall       (i_out_stall),
        .o_out_valid       (o_out_valid),
        .o_status          (o_status),
        .o_point_latitude  (o_point_latitude),
        .o_point_longitude (o_point_longitude),
        .o_point_altitude  (o_point_altitude),
        .o_entry_count     (o_entry_count)
    );

endmodule

### rtl/wti_checker.sv
module wti_checker #(
    parameter int TABLE_DEPTH = wti_pkg::TABLE_DEPTH_DEF
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [1:0]  o_status,
    input logic [31:0] o_point_latitude,
    input logic [31:0] o_point_longitude,
    input logic [31:0] o_point_altitude,
    input logic [6:0]  o_entry_count
);

    localparam logic [63:0] DEPTH_EXT = 64'(TABLE_DEPTH);

    // a stalled result holds its status, latitude and entry count
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status)
            && $stable(o_point_latitude) && $stable(o_entry_count))
        else $error("result changed under stall");

    // point fields are zero with an error status
    a_pt_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != wti_pkg::ST_OK) |->
            (o_point_latitude == 32'd0) && (o_point_longitude == 32'd0)
            && (o_point_altitude == 32'd0))
        else $error("nonzero point with error status");

    // a full report comes only with a full table
    a_full_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == wti_pkg::ST_FULL) |->
            o_entry_count == DEPTH_EXT[6:0])
        else $error("table full reported with wrong count");

    // an accepted item keeps the block busy in the next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second transfer right after a transfer");

endmodule

bind waypoint_table_interpolator wti_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_chk (.*);
